// File: sv/rbsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_pkg
// shared types and codes of the range bit set/clear/flip/count block
// ----------------------------------------------------------------------------
package rbsc_pkg;

  localparam int CMD_W   = 2;
  localparam int INDEX_W = 16;
  localparam int COUNT_W = 17;
  localparam int ECNT_W  = 17;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // register index, taken from paddr[2]
  localparam logic REG_ELEMENT_COUNT = 1'b0;
  localparam logic [ECNT_W-1:0] ECNT_RESET = 17'h10000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET    = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_INVERT = 2'd2,
    CMD_COUNT  = 2'd3
  } cmd_e;

  // deferred tag per tree node
  typedef enum logic [1:0] {
    TAG_NONE   = 2'd0,
    TAG_INVERT = 2'd1,
    TAG_ZERO   = 2'd2,
    TAG_ONE    = 2'd3
  } tag_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_A,
    ST_PUSH_B,
    ST_PUSH_C,
    ST_PUSH_D,
    ST_APPLY_CHK,
    ST_APPLY_RD,
    ST_APPLY_MOD,
    ST_PULL_A,
    ST_PULL_B,
    ST_PULL_C,
    ST_OUT
  } state_e;

endpackage
`default_nettype wire

// File: sv/range_bit_set_clear_flip_count_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_bit_set_clear_flip_count_top
// range set / clear / invert / count-ones over a bit store kept as a lazy
// segment tree of ones counts in one synchronous ram
// ----------------------------------------------------------------------------
// sequence: a count over an empty range goes from acceptance straight to the
//   output state; any other count gives its result after the push and apply
//   walks, and an update holds the block through the push, apply and pull walks
// throughput: one transaction at a time; the walk is bounded by the single
//   ram read port and write port (one node access of each kind per cycle)
// reset: asynchronous, active low; a clearing pass then zeroes every node
//   while no transaction is accepted
module range_bit_set_clear_flip_count_top #(
  parameter int MAX_POSITIONS = 65536
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // input transactions
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [rbsc_pkg::CMD_W-1:0]         command_i,
  input  wire  [rbsc_pkg::INDEX_W-1:0]       first_index_i,
  input  wire  [rbsc_pkg::INDEX_W-1:0]       last_index_i,
  // result transactions
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [rbsc_pkg::COUNT_W-1:0]       ones_count_o,
  // configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [rbsc_pkg::APB_AW-1:0]        paddr,
  input  wire  [rbsc_pkg::APB_DW-1:0]        pwdata,
  output logic [rbsc_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  // tree geometry: leaves are nodes 2^L .. 2^(L+1)-1, root is node 1
  localparam int L     = $clog2(MAX_POSITIONS);
  localparam int NAW   = L + 1;                     // node address bits
  localparam int DEPTH = 2 * (1 << L);
  localparam int CW    = L + 1;                     // node count bits
  localparam int EW    = CW + 2;                    // count + tag
  localparam int HW    = $clog2(L + 1);             // level counter bits
  localparam int XW    = (L + 1 > 17) ? L + 1 : 17; // clip compare width

  // apply a whole-node tag to a stored entry
  function automatic logic [EW-1:0] apply_tag(input logic [EW-1:0] e,
                                              input rbsc_pkg::tag_e t,
                                              input logic [CW-1:0] len);
    rbsc_pkg::tag_e   old;
    logic [CW-1:0]    cnt;
    logic [EW-1:0]    res;
    old = rbsc_pkg::tag_e'(e[1:0]);
    cnt = e[EW-1:2];
    res = e;
    case (t)
      rbsc_pkg::TAG_ONE:  res = {len, rbsc_pkg::TAG_ONE};
      rbsc_pkg::TAG_ZERO: res = {CW'(0), rbsc_pkg::TAG_ZERO};
      rbsc_pkg::TAG_INVERT: begin
        case (old)
          rbsc_pkg::TAG_ONE:    res = {CW'(0), rbsc_pkg::TAG_ZERO};
          rbsc_pkg::TAG_ZERO:   res = {len, rbsc_pkg::TAG_ONE};
          rbsc_pkg::TAG_INVERT: res = {len - cnt, rbsc_pkg::TAG_NONE};
          default:              res = {len - cnt, rbsc_pkg::TAG_INVERT};
        endcase
      end
      default: res = e;
    endcase
    return res;
  endfunction

  // state
  rbsc_pkg::state_e state_q, state_d;
  logic [NAW-1:0]   clr_q, clr_d;
  rbsc_pkg::tag_e   tag_q, tag_d;        // tag of the current command
  logic             is_count_q, is_count_d;
  logic [NAW-1:0]   l0_q, l0_d;          // leaf of first position
  logic [NAW-1:0]   r0_q, r0_d;          // leaf of last position
  logic [HW-1:0]    lvl_q, lvl_d;        // push / pull level above the leaves
  logic             side_q, side_d;      // 0 left boundary path, 1 right
  rbsc_pkg::tag_e   ptag_q, ptag_d;      // tag being pushed down
  logic [CW-1:0]    xcnt_q, xcnt_d;      // left child count during pull
  logic [NAW:0]     al_q, al_d;          // half-open node range of the apply walk
  logic [NAW:0]     ar_q, ar_d;
  logic [HW-1:0]    k_q, k_d;            // level of the apply walk
  logic [NAW-1:0]   tgt_q, tgt_d;
  logic [CW-1:0]    sum_q, sum_d;
  logic             out_valid_q, out_valid_d;
  logic [rbsc_pkg::COUNT_W-1:0] out_q, out_d;
  logic [rbsc_pkg::ECNT_W-1:0]  ecnt_q, ecnt_d;

  // ram port
  logic           ram_we, ram_re;
  logic [NAW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0]  ram_wdata, ram_rdata;
  logic [CW-1:0]  rd_cnt;
  rbsc_pkg::tag_e rd_tag;

  // index clipping at acceptance
  logic [XW-1:0]  n_x, last_x, first_x, lastc_x;
  logic           range_empty;
  logic           in_fire, cfg_wr;

  // boundary path helpers
  logic [NAW:0]   hmask, r1;
  logic           path_cond;
  logic [NAW-1:0] px, child0, child1;
  logic [CW-1:0]  clen, alen;

  rbsc_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_tree_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_cnt = ram_rdata[EW-1:2];
  assign rd_tag = rbsc_pkg::tag_e'(ram_rdata[1:0]);

  // configuration port, single register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == rbsc_pkg::REG_ELEMENT_COUNT);
  assign prdata = (paddr[2] == rbsc_pkg::REG_ELEMENT_COUNT) ?
                  rbsc_pkg::APB_DW'(ecnt_q) : '0;

  // handshake
  assign in_ready_o   = (state_q == rbsc_pkg::ST_IDLE);
  assign in_fire      = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign ones_count_o = out_q;

  // clip last index to the active element count, zero counts as one
  always_comb begin
    if (ecnt_q == '0) begin
      n_x = XW'(1);
    end else if (XW'(ecnt_q) > XW'(MAX_POSITIONS)) begin
      n_x = XW'(MAX_POSITIONS);
    end else begin
      n_x = XW'(ecnt_q);
    end
    last_x      = XW'(last_index_i);
    first_x     = XW'(first_index_i);
    lastc_x     = (last_x > n_x - XW'(1)) ? n_x - XW'(1) : last_x;
    range_empty = first_x > lastc_x;
  end

  // node on the current boundary path, and whether that path splits there
  always_comb begin
    hmask     = ((NAW+1)'(1) << lvl_q) - (NAW+1)'(1);
    r1        = {1'b0, r0_q} + (NAW+1)'(1);
    path_cond = side_q ? |(r1 & hmask) : |({1'b0, l0_q} & hmask);
    px        = side_q ? (r0_q >> lvl_q) : (l0_q >> lvl_q);
    child0    = {px[NAW-2:0], 1'b0};
    child1    = {px[NAW-2:0], 1'b1};
    clen      = CW'(1) << (lvl_q - HW'(1));
    alen      = CW'(1) << k_q;
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    tag_d       = tag_q;
    is_count_d  = is_count_q;
    l0_d        = l0_q;
    r0_d        = r0_q;
    lvl_d       = lvl_q;
    side_d      = side_q;
    ptag_d      = ptag_q;
    xcnt_d      = xcnt_q;
    al_d        = al_q;
    ar_d        = ar_q;
    k_d         = k_q;
    tgt_d       = tgt_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ecnt_d      = cfg_wr ? pwdata[rbsc_pkg::ECNT_W-1:0] : ecnt_q;
    ram_we      = 1'b0;
    ram_waddr   = px;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = px;

    case (state_q)
      rbsc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + NAW'(1);
        if (clr_q == NAW'(DEPTH - 1)) begin
          state_d = rbsc_pkg::ST_IDLE;
        end
      end

      rbsc_pkg::ST_IDLE: begin
        if (in_fire) begin
          is_count_d = (rbsc_pkg::cmd_e'(command_i) == rbsc_pkg::CMD_COUNT);
          case (rbsc_pkg::cmd_e'(command_i))
            rbsc_pkg::CMD_SET:    tag_d = rbsc_pkg::TAG_ONE;
            rbsc_pkg::CMD_CLEAR:  tag_d = rbsc_pkg::TAG_ZERO;
            rbsc_pkg::CMD_INVERT: tag_d = rbsc_pkg::TAG_INVERT;
            default:              tag_d = rbsc_pkg::TAG_NONE;
          endcase
          l0_d   = {1'b1, first_x[L-1:0]};
          r0_d   = {1'b1, lastc_x[L-1:0]};
          lvl_d  = HW'(L);
          side_d = 1'b0;
          sum_d  = '0;
          if (!range_empty) begin
            state_d = rbsc_pkg::ST_PUSH_A;
          end else if (rbsc_pkg::cmd_e'(command_i) == rbsc_pkg::CMD_COUNT) begin
            state_d = rbsc_pkg::ST_OUT;
          end
        end
      end

      // push pending tags down both boundary paths, root first
      rbsc_pkg::ST_PUSH_A: begin
        if (path_cond) begin
          ram_re    = 1'b1;
          ram_raddr = px;
          state_d   = rbsc_pkg::ST_PUSH_B;
        end else begin
          state_d = rbsc_pkg::ST_PUSH_D;
        end
      end

      rbsc_pkg::ST_PUSH_B: begin
        if (rd_tag == rbsc_pkg::TAG_NONE) begin
          state_d = rbsc_pkg::ST_PUSH_D;
        end else begin
          ptag_d    = rd_tag;
          ram_we    = 1'b1;
          ram_waddr = px;
          ram_wdata = {rd_cnt, rbsc_pkg::TAG_NONE};
          ram_re    = 1'b1;
          ram_raddr = child0;
          state_d   = rbsc_pkg::ST_PUSH_C;
        end
      end

      rbsc_pkg::ST_PUSH_C: begin
        ram_we    = 1'b1;
        ram_waddr = child0;
        ram_wdata = apply_tag(ram_rdata, ptag_q, clen);
        ram_re    = 1'b1;
        ram_raddr = child1;
        ptag_d    = ptag_q;
        state_d   = rbsc_pkg::ST_PUSH_D;
        // mark that child1 still needs its write
        xcnt_d    = '1;
      end

      rbsc_pkg::ST_PUSH_D: begin
        // child1 write only when arriving from the child0 write
        if (xcnt_q == '1) begin
          ram_we    = 1'b1;
          ram_waddr = child1;
          ram_wdata = apply_tag(ram_rdata, ptag_q, clen);
        end
        xcnt_d = '0;
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = rbsc_pkg::ST_PUSH_A;
        end else begin
          side_d = 1'b0;
          if (lvl_q == HW'(1)) begin
            al_d    = {1'b0, l0_q};
            ar_d    = {1'b0, r0_q} + (NAW+1)'(1);
            k_d     = '0;
            state_d = rbsc_pkg::ST_APPLY_CHK;
          end else begin
            lvl_d   = lvl_q - HW'(1);
            state_d = rbsc_pkg::ST_PUSH_A;
          end
        end
      end

      // bottom-up walk over the covering nodes
      rbsc_pkg::ST_APPLY_CHK: begin
        if (al_q >= ar_q) begin
          if (is_count_q) begin
            state_d = rbsc_pkg::ST_OUT;
          end else begin
            lvl_d   = HW'(1);
            side_d  = 1'b0;
            state_d = rbsc_pkg::ST_PULL_A;
          end
        end else if (al_q[0]) begin
          tgt_d   = al_q[NAW-1:0];
          al_d    = al_q + (NAW+1)'(1);
          state_d = rbsc_pkg::ST_APPLY_RD;
        end else if (ar_q[0]) begin
          ar_d    = ar_q - (NAW+1)'(1);
          tgt_d   = ar_d[NAW-1:0];
          state_d = rbsc_pkg::ST_APPLY_RD;
        end else begin
          al_d = al_q >> 1;
          ar_d = ar_q >> 1;
          k_d  = k_q + HW'(1);
        end
      end

      rbsc_pkg::ST_APPLY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = tgt_q;
        state_d   = rbsc_pkg::ST_APPLY_MOD;
      end

      rbsc_pkg::ST_APPLY_MOD: begin
        if (is_count_q) begin
          sum_d = sum_q + rd_cnt;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = tgt_q;
          ram_wdata = apply_tag(ram_rdata, tag_q, alen);
        end
        state_d = rbsc_pkg::ST_APPLY_CHK;
      end

      // rebuild counts up both boundary paths
      rbsc_pkg::ST_PULL_A: begin
        if (path_cond) begin
          ram_re    = 1'b1;
          ram_raddr = child0;
          state_d   = rbsc_pkg::ST_PULL_B;
        end else begin
          state_d = rbsc_pkg::ST_PULL_C;
        end
      end

      rbsc_pkg::ST_PULL_B: begin
        xcnt_d    = rd_cnt;
        ram_re    = 1'b1;
        ram_raddr = child1;
        state_d   = rbsc_pkg::ST_PULL_C;
      end

      rbsc_pkg::ST_PULL_C: begin
        if (path_cond) begin
          ram_we    = 1'b1;
          ram_waddr = px;
          ram_wdata = {xcnt_q + rd_cnt, rbsc_pkg::TAG_NONE};
        end
        xcnt_d = '0;
        if (!side_q) begin
          side_d  = 1'b1;
          state_d = rbsc_pkg::ST_PULL_A;
        end else begin
          side_d = 1'b0;
          if (lvl_q == HW'(L)) begin
            state_d = rbsc_pkg::ST_IDLE;
          end else begin
            lvl_d   = lvl_q + HW'(1);
            state_d = rbsc_pkg::ST_PULL_A;
          end
        end
      end

      // hand the count to the output register once it is free
      rbsc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = rbsc_pkg::COUNT_W'(sum_q);
          out_valid_d = 1'b1;
          state_d     = rbsc_pkg::ST_IDLE;
        end
      end

      default: state_d = rbsc_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbsc_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      ecnt_q      <= rbsc_pkg::ECNT_RESET;
      lvl_q       <= '0;
      side_q      <= 1'b0;
      k_q         <= '0;
      xcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      ecnt_q      <= ecnt_d;
      lvl_q       <= lvl_d;
      side_q      <= side_d;
      k_q         <= k_d;
      xcnt_q      <= xcnt_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    is_count_q <= is_count_d;
    l0_q       <= l0_d;
    r0_q       <= r0_d;
    ptag_q     <= ptag_d;
    al_q       <= al_d;
    ar_q       <= ar_d;
    tgt_q      <= tgt_d;
    sum_q      <= sum_d;
    out_q      <= out_d;
  end

endmodule
`default_nettype wire

// File: sv/rbsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbsc_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 131072
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/rbsc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsc_checker
// port-level checks of the range bit block, bound to the top level
// ----------------------------------------------------------------------------
module rbsc_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_o,
  input wire [1:0]  command_i,
  input wire        out_valid_o,
  input wire        out_ready_i,
  input wire [16:0] ones_count_o
);

  // stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(ones_count_o))
    else $error("result changed while stalled");

  // a count never exceeds the tree size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ones_count_o <= 17'h10000)
    else $error("count out of range");

  // a count transaction always occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && command_i == rbsc_pkg::CMD_COUNT |=> !in_ready_o)
    else $error("count transaction did not hold the block");

  // a new result is only loaded while no transaction can be accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a busy cycle");

endmodule

bind range_bit_set_clear_flip_count_top rbsc_checker u_rbsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .command_i   (command_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .ones_count_o(ones_count_o)
);
`default_nettype wire
